### design/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg: shared definitions for the paced release queue
// Request and status codes, command types and default sizes.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;
  localparam int TIME_WIDTH_DEF  = 48;
  localparam int SPACING_W       = 24;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [1:0] ST_DONE           = 2'd0;
  localparam logic [1:0] ST_EMPTY_OR_EARLY = 2'd1;
  localparam logic [1:0] ST_FULL           = 2'd2;
  localparam logic [1:0] ST_NOT_QUEUED     = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_IGNORE  = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_ctl_t;

endpackage
`default_nettype wire

### design/prq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_front: request intake
// Decode each accepted item into a command and hold it in a short queue.
// ----------------------------------------------------------------------------
module prq_front #(
  parameter int ID_WIDTH   = prq_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH = prq_pkg::TIME_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [1:0]             in_req_type,
  input  wire  [ID_WIDTH-1:0]    in_client_id,
  input  wire  [TIME_WIDTH-1:0]  in_current_time_us,
  output prq_pkg::cmd_ctl_t      cmd_ctl,
  output logic [ID_WIDTH-1:0]    cmd_id,
  output logic [TIME_WIDTH-1:0]  cmd_now,
  input  wire                    cmd_take
);
  import prq_pkg::*;

  localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int FW = $clog2(CMDQ_DEPTH + 1);

  op_t                   op_q  [CMDQ_DEPTH];
  logic [ID_WIDTH-1:0]   id_q  [CMDQ_DEPTH];
  logic [TIME_WIDTH-1:0] now_q [CMDQ_DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  op_t           op_dec;
  logic          push;
  logic          pop;

  always_comb begin
    case (in_req_type)
      REQ_ADD:     op_dec = OP_ADD;
      REQ_REMOVE:  op_dec = OP_REMOVE;
      REQ_RELEASE: op_dec = OP_RELEASE;
      default:     op_dec = OP_IGNORE;
    endcase
  end

  assign in_stall = (fill_r == FW'(CMDQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = cmd_take && (fill_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r]  <= op_dec;
      id_q[wr_ptr_r]  <= in_client_id;
      now_q[wr_ptr_r] <= in_current_time_us;
    end
  end

  assign cmd_ctl.valid = (fill_r != '0);
  assign cmd_ctl.op    = op_q[rd_ptr_r];
  assign cmd_id        = id_q[rd_ptr_r];
  assign cmd_now       = now_q[rd_ptr_r];

endmodule
`default_nettype wire

### design/prq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_back: entry chain and command execution
// Hold entries in a shifting cell chain, execute one command per cycle unless stalled.
// ----------------------------------------------------------------------------
module prq_back #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = prq_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH  = prq_pkg::TIME_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr_en,
  input  wire  [prq_pkg::SPACING_W-1:0]  cfg_release_spacing_us,
  input  prq_pkg::cmd_ctl_t              cmd_ctl,
  input  wire  [ID_WIDTH-1:0]            cmd_id,
  input  wire  [TIME_WIDTH-1:0]          cmd_now,
  output logic                           cmd_take,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_released,
  output logic [ID_WIDTH-1:0]            out_released_id,
  output logic [TIME_WIDTH-1:0]          out_granted_time_us,
  output logic [1:0]                     out_status
);
  import prq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [ID_WIDTH-1:0]   ids_r   [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0]   ids_nxt [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] times_r   [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] times_nxt [QUEUE_DEPTH];
  logic [CW-1:0]         count_r, count_nxt;
  logic [TIME_WIDTH-1:0] last_r, last_nxt;
  logic [SPACING_W-1:0]  spacing_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  released_r, released_nxt;
  logic [ID_WIDTH-1:0]   rel_id_r, rel_id_nxt;
  logic [TIME_WIDTH-1:0] granted_r, granted_nxt;
  logic [1:0]            status_r, status_nxt;

  logic                  exec;
  logic                  full;
  logic                  empty;
  logic [IW-1:0]         tail_idx;
  logic [TIME_WIDTH-1:0] base_time;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] sat_time;
  logic [TIME_WIDTH-1:0] grant_time;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] lowest;
  logic [QUEUE_DEPTH-1:0] shift_mask;
  logic [QUEUE_DEPTH-1:0] shift_en;
  logic                  hit;
  logic                  release_ok;

  assign cmd_take = !out_valid_r || !out_stall;
  assign exec     = cmd_ctl.valid && cmd_take;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign tail_idx = IW'(count_r - 1'b1);

  // Grant time: tail plus spacing, or if empty the later of now and last release plus spacing; saturating.
  assign base_time  = empty ? last_r : times_r[tail_idx];
  assign sum        = {1'b0, base_time} + (TIME_WIDTH + 1)'(spacing_r);
  assign sat_time   = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
  assign grant_time = (empty && (cmd_now > sat_time)) ? cmd_now : sat_time;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CW'(i) < count_r) && (ids_r[i] == cmd_id);
    end
  end

  // Isolate the match nearest the head; every cell from there on shifts.
  assign lowest     = match & (~match + 1'b1);
  assign hit        = |match;
  assign shift_mask = hit ? ~(lowest - 1'b1) : '0;
  assign release_ok = !empty && (times_r[0] <= cmd_now);

  always_comb begin
    ids_nxt      = ids_r;
    times_nxt    = times_r;
    count_nxt    = count_r;
    last_nxt     = last_r;
    shift_en     = '0;
    released_nxt = 1'b0;
    rel_id_nxt   = '0;
    granted_nxt  = '0;
    status_nxt   = ST_EMPTY_OR_EARLY;
    if (exec) begin
      case (cmd_ctl.op)
        OP_ADD: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ids_nxt[count_r[IW-1:0]]   = cmd_id;
            times_nxt[count_r[IW-1:0]] = grant_time;
            count_nxt                  = count_r + 1'b1;
            granted_nxt                = grant_time;
            status_nxt                 = ST_DONE;
          end
        end
        OP_REMOVE: begin
          status_nxt = ST_NOT_QUEUED;
          if (hit) begin
            shift_en   = shift_mask;
            count_nxt  = count_r - 1'b1;
            status_nxt = ST_DONE;
          end
        end
        OP_RELEASE: begin
          if (release_ok) begin
            released_nxt = 1'b1;
            rel_id_nxt   = ids_r[0];
            last_nxt     = times_r[0];
            shift_en     = '1;
            count_nxt    = count_r - 1'b1;
            status_nxt   = ST_DONE;
          end
        end
        default: begin
          status_nxt = ST_EMPTY_OR_EARLY;
        end
      endcase
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (shift_en[i]) begin
        ids_nxt[i]   = ids_r[i + 1];
        times_nxt[i] = times_r[i + 1];
      end
    end
    if (cfg_wr_en) begin
      last_nxt = '0;
    end
  end

  always_comb begin
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      last_r      <= '0;
      spacing_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        spacing_r <= cfg_release_spacing_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    ids_r   <= ids_nxt;
    times_r <= times_nxt;
    if (exec) begin
      released_r <= released_nxt;
      rel_id_r   <= rel_id_nxt;
      granted_r  <= granted_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_released        = released_r;
  assign out_released_id     = rel_id_r;
  assign out_granted_time_us = granted_r;
  assign out_status          = status_r;

endmodule
`default_nettype wire

### design/paced_release_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Results are registered: an item passes the command queue, then the output register.
// Throughput: one item per cycle while results are not stalled at the output.
// Input is held off only while the two-entry command queue is full.
// Reset (rst_n low, synchronous) empties both queues, clears the spacing
// register and the last release time, and drops any pending result.
// ----------------------------------------------------------------------------
// paced_release_queue: FIFO of client ids released at a minimum spacing
// Front decodes requests into a command queue; back runs them on a cell chain.
// ----------------------------------------------------------------------------
module paced_release_queue #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = prq_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH  = prq_pkg::TIME_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // spacing register
  input  wire                            cfg_wr_en,
  input  wire  [prq_pkg::SPACING_W-1:0]  cfg_release_spacing_us,
  // request items
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [1:0]                     in_req_type,
  input  wire  [ID_WIDTH-1:0]            in_client_id,
  input  wire  [TIME_WIDTH-1:0]          in_current_time_us,
  // result items
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_released,
  output logic [ID_WIDTH-1:0]            out_released_id,
  output logic [TIME_WIDTH-1:0]          out_granted_time_us,
  output logic [1:0]                     out_status
);
  import prq_pkg::*;

  // Command handoff between the intake and the execution side.
  cmd_ctl_t              cmd_ctl;
  logic [ID_WIDTH-1:0]   cmd_id;
  logic [TIME_WIDTH-1:0] cmd_now;
  logic                  cmd_take;

  // Intake: decode the request type and park the item in the command queue,
  // so a stalled result never blocks the input side at once.
  prq_front #(
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_client_id       (in_client_id),
    .in_current_time_us (in_current_time_us),
    .cmd_ctl            (cmd_ctl),
    .cmd_id             (cmd_id),
    .cmd_now            (cmd_now),
    .cmd_take           (cmd_take)
  );

  // Execution: adds write the tail cell, removes shift the chain down from
  // the matching cell and releases from the head cell; the result lands in an
  // output register that holds while the consumer stalls.
  prq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_release_spacing_us (cfg_release_spacing_us),
    .cmd_ctl                (cmd_ctl),
    .cmd_id                 (cmd_id),
    .cmd_now                (cmd_now),
    .cmd_take               (cmd_take),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_released           (out_released),
    .out_released_id        (out_released_id),
    .out_granted_time_us    (out_granted_time_us),
    .out_status             (out_status)
  );

endmodule
`default_nettype wire

### design/prq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_checker: port-level checks for the paced release queue
// Cross-field consistency of result items and reset behaviour.
// ----------------------------------------------------------------------------
module prq_checker #(
  parameter int ID_WIDTH   = prq_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH = prq_pkg::TIME_WIDTH_DEF
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_valid,
  input wire                   out_released,
  input wire [ID_WIDTH-1:0]    out_released_id,
  input wire [TIME_WIDTH-1:0]  out_granted_time_us,
  input wire [1:0]             out_status
);
  import prq_pkg::*;

  // Drop any pending result on reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A release always reports done and carries no grant time.
  a_release_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_released) |->
      (out_status == ST_DONE && out_granted_time_us == '0))
    else $error("release with bad status or grant time");

  // No release means no released id.
  a_no_release_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_released) |-> (out_released_id == '0))
    else $error("released id set without a release");

  // Failure codes never come with a release or a grant.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NOT_QUEUED ||
                   out_status == ST_EMPTY_OR_EARLY)) |->
      (!out_released && out_granted_time_us == '0))
    else $error("failed request reports release or grant");

endmodule

bind paced_release_queue prq_checker #(
  .ID_WIDTH   (ID_WIDTH),
  .TIME_WIDTH (TIME_WIDTH)
) u_prq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_released        (out_released),
  .out_released_id     (out_released_id),
  .out_granted_time_us (out_granted_time_us),
  .out_status          (out_status)
);
`default_nettype wire

### dv/paced_release_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paced_release_queue_tb: self-checking bench for the paced release queue
// Drives add, remove and try-release requests with random gaps and output
// stalls, predicts every result from a local copy of the queue and compares
// each result item field by field in arrival order.
// ----------------------------------------------------------------------------
module paced_release_queue_tb;
  import prq_pkg::*;

  localparam int          QDEPTH       = QUEUE_DEPTH_DEF;
  localparam logic [47:0] TIME_MAX     = {48{1'b1}};
  localparam int          LIMIT_CYCLES = 400000;

  // One result item as the block presents it
  typedef struct packed {
    logic        released;
    logic [7:0]  released_id;
    logic [47:0] granted_time_us;
    logic [1:0]  status;
  } prq_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [23:0] cfg_release_spacing_us;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_client_id;
  logic [47:0] in_current_time_us;
  logic        out_valid;
  logic        out_stall;
  logic        out_released;
  logic [7:0]  out_released_id;
  logic [47:0] out_granted_time_us;
  logic [1:0]  out_status;

  // Local copy of the queue, the spacing register and the last release time
  logic [7:0]  held_id  [QDEPTH];
  logic [47:0] held_rel [QDEPTH];
  int          held_count;
  logic [47:0] last_release_us;
  logic [23:0] spacing_us;

  prq_result_t awaited_results[$];
  prq_result_t head_result;
  int          fail_count;
  int          cycle_count;
  int          stall_left;
  bit          no_idle;
  logic [47:0] now_us;

  paced_release_queue u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_release_spacing_us (cfg_release_spacing_us),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_client_id           (in_client_id),
    .in_current_time_us     (in_current_time_us),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_released           (out_released),
    .out_released_id        (out_released_id),
    .out_granted_time_us    (out_granted_time_us),
    .out_status             (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if the handshakes stop moving
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (no_idle) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 75) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
  end

  // Add a time and a spacing, holding at the top of the time range
  function automatic logic [47:0] paced_add(input logic [47:0] base, input logic [23:0] d);
    logic [48:0] s;
    s = {1'b0, base} + {25'd0, d};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  // Input gap before the next item: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rel=%0b id=%0h grant=%0h st=%0d",
                 $time, out_released, out_released_id, out_granted_time_us, out_status);
        fail_count++;
      end else begin
        head_result = awaited_results.pop_front();
        report_field("released", head_result.released, out_released);
        report_field("released_id", head_result.released_id, out_released_id);
        report_field("granted_time_us", head_result.granted_time_us, out_granted_time_us);
        report_field("status", head_result.status, out_status);
      end
    end
  end

  // Work out the result of one accepted request and update the local queue
  task automatic predict_request(input logic [1:0] kind, input logic [7:0] id,
                                 input logic [47:0] now);
    prq_result_t res;
    logic [47:0] slot;
    bit          found;
    res        = '0;
    res.status = ST_EMPTY_OR_EARLY;
    found      = 1'b0;
    case (kind)
      REQ_ADD: begin
        if (held_count >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (held_count > 0) begin
            slot = paced_add(held_rel[held_count-1], spacing_us);
          end else begin
            slot = paced_add(last_release_us, spacing_us);
            if (now > slot) slot = now;
          end
          held_id[held_count]  = id;
          held_rel[held_count] = slot;
          held_count++;
          res.granted_time_us = slot;
          res.status          = ST_DONE;
        end
      end
      REQ_REMOVE: begin
        res.status = ST_NOT_QUEUED;
        for (int i = 0; i < held_count; i++) begin
          if (!found && held_id[i] == id) begin
            found = 1'b1;
            for (int j = i; j + 1 < held_count; j++) begin
              held_id[j]  = held_id[j+1];
              held_rel[j] = held_rel[j+1];
            end
          end
        end
        if (found) begin
          held_count--;
          res.status = ST_DONE;
        end
      end
      REQ_RELEASE: begin
        if (held_count > 0 && held_rel[0] <= now) begin
          res.released    = 1'b1;
          res.released_id = held_id[0];
          last_release_us = held_rel[0];
          for (int j = 0; j + 1 < held_count; j++) begin
            held_id[j]  = held_id[j+1];
            held_rel[j] = held_rel[j+1];
          end
          held_count--;
          res.status = ST_DONE;
        end
      end
      default: begin
        // unused request code: ignored, status only
      end
    endcase
    awaited_results.push_back(res);
  endtask

  // Present one item, hold it until accepted, then idle for a random gap
  task automatic send_request(input logic [1:0] kind, input logic [7:0] id,
                              input logic [47:0] now);
    int gap;
    in_valid           <= 1'b1;
    in_req_type        <= kind;
    in_client_id       <= id;
    in_current_time_us <= now;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_request(kind, id, now);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted result has come out
  task automatic wait_results_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write the spacing register while the block is idle; this also clears
  // the last release time
  task automatic set_spacing(input logic [23:0] sp);
    wait_results_idle();
    repeat (2) @(posedge clk);
    cfg_wr_en              <= 1'b1;
    cfg_release_spacing_us <= sp;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    spacing_us      = sp;
    last_release_us = '0;
  endtask

  // Empty-queue requests, the unused code, duplicates and a spaced release
  task automatic test_corner_requests();
    send_request(REQ_RELEASE, 8'h00, 48'd0);
    send_request(REQ_REMOVE, 8'h5A, 48'd0);
    send_request(OP_IGNORE, 8'hFF, TIME_MAX);
    send_request(REQ_ADD, 8'h00, 48'd0);
    send_request(REQ_ADD, 8'hFF, 48'd10);
    send_request(REQ_ADD, 8'h00, 48'd10);
    // the duplicate nearest the head goes
    send_request(REQ_REMOVE, 8'h00, 48'd10);
    send_request(REQ_RELEASE, 8'h11, 48'd10);
    send_request(REQ_RELEASE, 8'h00, 48'd10);
    set_spacing(24'd100);
    send_request(REQ_ADD, 8'h81, 48'd5);
    send_request(REQ_RELEASE, 8'h00, 48'd99);
    send_request(REQ_RELEASE, 8'h00, 48'd100);
    send_request(REQ_ADD, 8'h42, 48'd150);
    send_request(REQ_RELEASE, 8'h00, 48'd200);
  endtask

  // Release times near the top of the range saturate
  task automatic test_time_saturation();
    set_spacing(24'hFFFFFF);
    send_request(REQ_ADD, 8'h3C, TIME_MAX - 48'd5);
    send_request(REQ_ADD, 8'hC3, TIME_MAX - 48'd5);
    send_request(REQ_RELEASE, 8'h00, TIME_MAX);
    send_request(REQ_RELEASE, 8'h00, TIME_MAX);
    send_request(REQ_ADD, 8'h99, TIME_MAX - 48'd5);
    send_request(REQ_RELEASE, 8'h00, TIME_MAX);
  endtask

  // Fill the queue, overfill it, then remove absent, middle and tail ids
  task automatic test_full_queue();
    set_spacing(24'd0);
    for (int k = 1; k <= QDEPTH; k++) send_request(REQ_ADD, 8'(k), 48'd1000 + 48'(k));
    send_request(REQ_ADD, 8'h77, 48'd1020);
    send_request(REQ_REMOVE, 8'hC3, 48'd1020);
    send_request(REQ_REMOVE, 8'h08, 48'd1020);
    send_request(REQ_REMOVE, 8'h10, 48'd1020);
  endtask

  // One phase of random traffic at a given spacing; pause halfway until
  // every result has drained
  task automatic run_traffic_phase(input logic [23:0] sp, input int n_items, input bit calm);
    int              r;
    logic [1:0]      kind;
    logic [7:0]      id;
    longint unsigned t;
    longint unsigned span;
    set_spacing(sp);
    no_idle = calm;
    span    = longint'(sp) + 1;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_results_idle();
      // advance time, with the odd big jump and rare step backwards
      t = now_us;
      r = $urandom_range(0, 99);
      if (r < 30) t = t;
      else if (r < 80) t = t + $urandom_range(1, 32'(span));
      else if (r < 95) t = t + span * $urandom_range(2, 4);
      else if (r < 99) t = t + $urandom;
      else if (t > span) t = t - span;
      if (t > TIME_MAX) t = TIME_MAX;
      now_us = t[47:0];
      // pick the request, weighting away from adds when full
      r = $urandom_range(0, 99);
      if (held_count == QDEPTH && r < 40) r = r + 40;
      if (r < 40) kind = REQ_ADD;
      else if (r < 60) kind = REQ_REMOVE;
      else if (r < 95) kind = REQ_RELEASE;
      else kind = OP_IGNORE;
      id = 8'($urandom_range(0, 255));
      if (kind == REQ_ADD && $urandom_range(0, 1)) id = 8'($urandom_range(0, 7));
      if (kind == REQ_REMOVE && held_count > 0 && $urandom_range(0, 3) != 0)
        id = held_id[$urandom_range(0, held_count - 1)];
      send_request(kind, id, now_us);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    now_us = 48'd2000;
    run_traffic_phase(24'd0, 100, 1'b0);
    run_traffic_phase(24'd1, 100, 1'b1);
    run_traffic_phase(24'($urandom_range(2, 200)), 150, 1'b0);
    run_traffic_phase(24'($urandom_range(1000, 24'hFFFFFE)), 100, 1'b0);
    run_traffic_phase(24'hFFFFFF, 50, 1'b0);
    run_traffic_phase(24'($urandom_range(0, 24'hFFFFFF)), 100, 1'b0);
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_release_spacing_us = '0;
    in_valid               = 1'b0;
    in_req_type            = REQ_ADD;
    in_client_id           = '0;
    in_current_time_us     = '0;
    out_stall              = 1'b0;
    stall_left             = 0;
    no_idle                = 1'b0;
    fail_count             = 0;
    cycle_count            = 0;
    held_count             = 0;
    last_release_us        = '0;
    spacing_us             = '0;
    now_us                 = '0;
    // hold reset, then leave it high for the rest of the run
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_requests();
    test_time_saturation();
    test_full_queue();
    test_random_traffic();

    // drain, then report the outcome
    wait_results_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
design/prq_pkg.sv
design/prq_front.sv
design/prq_back.sv
design/paced_release_queue.sv
design/prq_checker.sv
dv/paced_release_queue_tb.sv
